### rtl/core/time_value_decimal_formatter_defines.svh
// Assertion macros for the time value decimal formatter.
`ifndef TIME_VALUE_DECIMAL_FORMATTER_DEFINES_SVH
`define TIME_VALUE_DECIMAL_FORMATTER_DEFINES_SVH

// same-cycle implication
`define TVDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TVDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tvdf_pkg.sv
// Types and constants of the time value decimal formatter.
package tvdf_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCALE,
		ST_ROUND,
		ST_SKIP,
		ST_SEC,
		ST_DOT,
		ST_FRAC
	} state_t;

	// configuration register indexes
	localparam logic [0:0] REG_DIGIT_WIDTH  = 1'd0;
	localparam logic [0:0] REG_MAX_DECIMALS = 1'd1;

	localparam logic [2:0] DIGIT_WIDTH_RESET  = 3'd3;
	localparam logic [2:0] MAX_DECIMALS_RESET = 3'd3;

	localparam int          US_BITS   = 20;
	localparam int          US_DIGITS = 6;
	localparam logic [19:0] US_MAX    = 20'd999999;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_POINT = 8'h2E;

	// decimal digits needed for 2**bits (largest seconds value after a rounding carry)
	function automatic int pow2_digits(input int bits);
		longint unsigned v;
		longint unsigned p;
		int n;
		v = longint'(1) << bits;
		p = 1;
		n = 0;
		for (int i = 0; i < 20; i++) begin
			if (p <= v) begin
				p = p * 10;
				n = n + 1;
			end
		end
		return n;
	endfunction

endpackage

### rtl/core/time_value_decimal_formatter.sv
// Time value decimal formatter: seconds plus microseconds to ASCII text, one character a cycle.
//
// Usage: present seconds and microseconds with start while busy is low; the
// transfer happens at that clock edge. The block converts both values to BCD
// with a bit-serial shift-and-add-3 converter, one binary bit per cycle,
// picks the resolution in the SCALE state and rounds by half a resolution
// step (with the carry into the seconds) in the ROUND state, drops leading
// zero seconds digits one per cycle (up to the seconds digit count minus
// one), then emits one character per cycle: seconds digits, and when a
// fraction remains, a point and the fraction digits without trailing zeros.
// Every seconds digit position is either skipped or printed. Results appear
// on character/last for exactly one cycle each, marked by strobe; the
// receiver cannot stall them, so it must take every strobed transfer. last
// marks the final character of the value. busy stays high until the final
// character has been launched; the next start may come in the cycle that
// shows it. Config writes (cfg_we/cfg_index/cfg_data) are meant for idle
// periods only; digit_width is held in 1..6 and max_decimals in 0..6
// on the write.
`include "time_value_decimal_formatter_defines.svh"

module time_value_decimal_formatter #(
	parameter int SECONDS_BITS = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// command channel
	input  logic                    start,
	output logic                    busy,
	input  logic [SECONDS_BITS-1:0] seconds,
	input  logic [19:0]             microseconds,
	// result channel
	output logic                    strobe,
	output logic [7:0]              character,
	output logic                    last,
	// configuration write port
	input  logic                    cfg_we,
	input  logic [0:0]              cfg_index,
	input  logic [2:0]              cfg_data
);

	localparam int CONV_BITS  = (SECONDS_BITS > tvdf_pkg::US_BITS) ?
	                            SECONDS_BITS : tvdf_pkg::US_BITS;
	localparam int CONV_CW    = $clog2(CONV_BITS);
	localparam int SEC_DIGITS = tvdf_pkg::pow2_digits(SECONDS_BITS);
	localparam int SEC_BCD_W  = 4 * SEC_DIGITS;
	localparam int DCNT_W     = $clog2(SEC_DIGITS + 1);
	localparam int US_DIG     = tvdf_pkg::US_DIGITS;
	localparam int US_BCD_W   = 4 * US_DIG;

	tvdf_pkg::state_t state_q, state_d;

	// configuration
	logic [2:0] wdt_q;
	logic [2:0] mx_q;

	// binary shifters and BCD accumulators
	logic [CONV_BITS-1:0]             sbin_q;
	logic [CONV_BITS-1:0]             ubin_q;
	logic [SEC_DIGITS-1:0][3:0]       sbcd_q;
	logic [US_DIG-1:0][3:0]           ubcd_q;
	logic [CONV_CW-1:0]               conv_cnt_q;
	logic [DCNT_W-1:0]                dig_cnt_q;
	logic [2:0]                       e_q;       // resolution exponent, 10^e us
	logic [US_DIG-1:0]                nz_q;      // fraction digits still to print

	// output register
	logic       stb_q;
	logic [7:0] char_q;
	logic       last_q;

	logic       stb_d;
	logic [7:0] char_d;
	logic       last_d;

	// ------------------------------------------------------------------
	// config write, clamped to the legal ranges
	// ------------------------------------------------------------------
	logic [2:0] wdt_wr;
	logic [2:0] mx_wr;

	always_comb begin
		wdt_wr = cfg_data;
		if (cfg_data == 3'd0)
			wdt_wr = 3'd1;
		else if (cfg_data == 3'd7)
			wdt_wr = 3'd6;
		mx_wr = (cfg_data == 3'd7) ? 3'd6 : cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wdt_q <= tvdf_pkg::DIGIT_WIDTH_RESET;
			mx_q  <= tvdf_pkg::MAX_DECIMALS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tvdf_pkg::REG_DIGIT_WIDTH:  wdt_q <= wdt_wr;
				tvdf_pkg::REG_MAX_DECIMALS: mx_q  <= mx_wr;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// shift-and-add-3 step: one binary bit into each BCD accumulator
	// ------------------------------------------------------------------
	logic [SEC_DIGITS-1:0][3:0] sadj_c;
	logic [US_DIG-1:0][3:0]     uadj_c;
	logic [SEC_BCD_W:0]         sshift_c;
	logic [US_BCD_W:0]          ushift_c;

	always_comb begin
		for (int p = 0; p < SEC_DIGITS; p++)
			sadj_c[p] = (sbcd_q[p] >= 4'd5) ? sbcd_q[p] + 4'd3 : sbcd_q[p];
		for (int p = 0; p < US_DIG; p++)
			uadj_c[p] = (ubcd_q[p] >= 4'd5) ? ubcd_q[p] + 4'd3 : ubcd_q[p];
		sshift_c = {sadj_c, sbin_q[CONV_BITS-1]};
		ushift_c = {uadj_c, ubin_q[CONV_BITS-1]};
	end

	// ------------------------------------------------------------------
	// resolution: exponent of the rounding step in microseconds
	// ------------------------------------------------------------------
	logic [3:0] dsec_c;   // significant seconds digits
	logic [2:0] dus_c;    // significant microsecond digits
	logic [3:0] wdt4_c;
	logic [3:0] min_c;
	logic [3:0] us_ex_c;
	logic [3:0] e0_c;
	logic [3:0] e_c;

	always_comb begin
		dsec_c = 4'd0;
		for (int p = 0; p < SEC_DIGITS; p++)
			if (sbcd_q[p] != 4'd0)
				dsec_c = 4'(p + 1);
		dus_c = 3'd0;
		for (int p = 0; p < US_DIG; p++)
			if (ubcd_q[p] != 4'd0)
				dus_c = 3'(p + 1);

		wdt4_c  = {1'b0, wdt_q};
		min_c   = (dsec_c > wdt4_c) ? wdt4_c : dsec_c;
		us_ex_c = (dus_c > wdt_q) ? {1'b0, dus_c - wdt_q} : 4'd0;
		e0_c    = 4'd6 - {1'b0, mx_q};

		if (mx_q == 3'd0)
			e_c = 4'd6;
		else if (dsec_c != 4'd0)
			e_c = 4'd6 - wdt4_c + min_c;        // from the seconds' magnitude
		else
			e_c = (us_ex_c > e0_c) ? us_ex_c : e0_c;
	end

	// ------------------------------------------------------------------
	// rounding: add 5 * 10^(e-1) to the fraction, carry into the seconds
	// ------------------------------------------------------------------
	logic [US_DIG-1:0][3:0]     urnd_c;
	logic [SEC_DIGITS-1:0][3:0] srnd_c;
	logic [US_DIG-1:0]          nz_c;
	logic                       ucarry_c;
	logic                       scarry_c;
	logic [4:0]                 sum_c;
	logic [3:0]                 add_c;

	always_comb begin
		ucarry_c = 1'b0;
		sum_c    = 5'd0;
		add_c    = 4'd0;
		for (int p = 0; p < US_DIG; p++) begin
			add_c = ((4'(p) + 4'd1) == {1'b0, e_q}) ? 4'd5 : 4'd0;
			sum_c = {1'b0, ubcd_q[p]} + {1'b0, add_c} + {4'd0, ucarry_c};
			if (sum_c >= 5'd10) begin
				urnd_c[p] = 4'(sum_c - 5'd10);
				ucarry_c  = 1'b1;
			end else begin
				urnd_c[p] = sum_c[3:0];
				ucarry_c  = 1'b0;
			end
		end
		// a carry out of the top fraction digit is one whole second
		scarry_c = ucarry_c;
		for (int p = 0; p < SEC_DIGITS; p++) begin
			if (scarry_c && (sbcd_q[p] == 4'd9)) begin
				srnd_c[p] = 4'd0;
			end else begin
				srnd_c[p] = sbcd_q[p] + {3'd0, scarry_c};
				scarry_c  = 1'b0;
			end
		end
		for (int p = 0; p < US_DIG; p++)
			nz_c[p] = (urnd_c[p] != 4'd0) && (3'(p) >= e_q);
	end

	// ------------------------------------------------------------------
	// control
	// ------------------------------------------------------------------
	logic [3:0] sec_top_c;
	logic       cnt_one_c;

	assign sec_top_c = sbcd_q[SEC_DIGITS-1];
	assign cnt_one_c = (dig_cnt_q == DCNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tvdf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tvdf_pkg::ST_IDLE:  if (start) state_d = tvdf_pkg::ST_CONV;
			tvdf_pkg::ST_CONV:  if (conv_cnt_q == '0) state_d = tvdf_pkg::ST_SCALE;
			tvdf_pkg::ST_SCALE: state_d = tvdf_pkg::ST_ROUND;
			tvdf_pkg::ST_ROUND: state_d = tvdf_pkg::ST_SKIP;
			tvdf_pkg::ST_SKIP:  if ((sec_top_c != 4'd0) || cnt_one_c)
				state_d = tvdf_pkg::ST_SEC;
			tvdf_pkg::ST_SEC:   if (cnt_one_c)
				state_d = (|nz_q) ? tvdf_pkg::ST_DOT : tvdf_pkg::ST_IDLE;
			tvdf_pkg::ST_DOT:   state_d = tvdf_pkg::ST_FRAC;
			tvdf_pkg::ST_FRAC:  if (~|nz_q[US_DIG-2:0]) state_d = tvdf_pkg::ST_IDLE;
			default:            state_d = tvdf_pkg::ST_IDLE;
		endcase
	end

	// character to launch this cycle
	always_comb begin
		stb_d  = 1'b0;
		char_d = tvdf_pkg::CHAR_ZERO;
		last_d = 1'b0;
		unique case (state_q)
			tvdf_pkg::ST_SEC: begin
				stb_d  = 1'b1;
				char_d = tvdf_pkg::CHAR_ZERO + {4'd0, sec_top_c};
				last_d = cnt_one_c && !(|nz_q);
			end
			tvdf_pkg::ST_DOT: begin
				stb_d  = 1'b1;
				char_d = tvdf_pkg::CHAR_POINT;
			end
			tvdf_pkg::ST_FRAC: begin
				stb_d  = 1'b1;
				char_d = tvdf_pkg::CHAR_ZERO + {4'd0, ubcd_q[US_DIG-1]};
				last_d = ~|nz_q[US_DIG-2:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stb_q      <= 1'b0;
			last_q     <= 1'b0;
			conv_cnt_q <= '0;
			dig_cnt_q  <= '0;
		end else begin
			stb_q  <= stb_d;
			last_q <= last_d;
			unique case (state_q)
				tvdf_pkg::ST_IDLE:  conv_cnt_q <= CONV_CW'(CONV_BITS - 1);
				tvdf_pkg::ST_CONV:  conv_cnt_q <= conv_cnt_q - CONV_CW'(1);
				tvdf_pkg::ST_ROUND: dig_cnt_q  <= DCNT_W'(SEC_DIGITS);
				tvdf_pkg::ST_SKIP:
					if ((sec_top_c == 4'd0) && !cnt_one_c)
						dig_cnt_q <= dig_cnt_q - DCNT_W'(1);
				tvdf_pkg::ST_SEC:   dig_cnt_q <= dig_cnt_q - DCNT_W'(1);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		char_q <= char_d;
		unique case (state_q)
			tvdf_pkg::ST_IDLE:
				if (start) begin
					sbin_q <= CONV_BITS'(seconds);
					ubin_q <= CONV_BITS'((microseconds > tvdf_pkg::US_MAX) ?
					                     tvdf_pkg::US_MAX : microseconds);
					sbcd_q <= '0;
					ubcd_q <= '0;
				end
			tvdf_pkg::ST_CONV: begin
				sbin_q <= {sbin_q[CONV_BITS-2:0], 1'b0};
				ubin_q <= {ubin_q[CONV_BITS-2:0], 1'b0};
				sbcd_q <= sshift_c[SEC_BCD_W-1:0];
				ubcd_q <= ushift_c[US_BCD_W-1:0];
			end
			tvdf_pkg::ST_SCALE: e_q <= e_c[2:0];
			tvdf_pkg::ST_ROUND: begin
				sbcd_q <= srnd_c;
				ubcd_q <= urnd_c;
				nz_q   <= nz_c;
			end
			tvdf_pkg::ST_SKIP:
				if ((sec_top_c == 4'd0) && !cnt_one_c)
					sbcd_q <= {sbcd_q[SEC_DIGITS-2:0], 4'd0};
			tvdf_pkg::ST_SEC: sbcd_q <= {sbcd_q[SEC_DIGITS-2:0], 4'd0};
			tvdf_pkg::ST_FRAC: begin
				ubcd_q <= {ubcd_q[US_DIG-2:0], 4'd0};
				nz_q   <= {nz_q[US_DIG-2:0], 1'b0};
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != tvdf_pkg::ST_IDLE);
	assign strobe    = stb_q;
	assign character = char_q;
	assign last      = last_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`TVDF_ASSERT_NEXT(a_start_quiet, clk, arst_n, start && !busy, busy && !strobe,
		"accepted command must not be followed by a stray transfer")
	`TVDF_ASSERT_NOW(a_last_idle, clk, arst_n, strobe && last, !busy,
		"final character shown while the formatter is still busy")
	`TVDF_ASSERT_NOW(a_more_busy, clk, arst_n, strobe && !last, busy,
		"non-final character with no further characters pending")
	`TVDF_ASSERT_NOW(a_char_set, clk, arst_n, strobe,
		(character == tvdf_pkg::CHAR_POINT) ||
		((character >= tvdf_pkg::CHAR_ZERO) && (character <= tvdf_pkg::CHAR_NINE)),
		"character outside digits and point")

endmodule

### verif/tb.sv
// Self-checking testbench for time_value_decimal_formatter: random and directed time values.
module tb;

	localparam int SEC_BITS = 31;
	// generous bound: ~390 values, each with its conversion, gap and drain, with margin
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 37;

	localparam longint unsigned ONE_MILLION = 64'd1000000;
	localparam longint unsigned POW10 [7] = '{1, 10, 100, 1000, 10000, 100000, 1000000};

	// one character of formatted text
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} text_char_t;

	// one time value waiting to be sent
	typedef struct packed {
		logic [SEC_BITS-1:0] sec;
		logic [19:0]         usec;
	} time_value_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [SEC_BITS-1:0] seconds = '0;
	logic [19:0]         microseconds = '0;
	logic                strobe;
	logic [7:0]          character;
	logic                last;
	logic                cfg_we = 1'b0;
	logic [0:0]          cfg_index = tvdf_pkg::REG_DIGIT_WIDTH;
	logic [2:0]          cfg_data = '0;

	// shadow copies of the two registers, as written (clamping happens at use)
	logic [2:0] digit_width_cfg = tvdf_pkg::DIGIT_WIDTH_RESET;
	logic [2:0] max_decimals_cfg = tvdf_pkg::MAX_DECIMALS_RESET;

	time_value_t pending_values[$];
	text_char_t  expected_text[$];
	int          error_count = 0;
	int          cycle_count = 0;

	// sender pacing
	int          burst_left = 0;
	int          gap_left = 0;
	bit          draining = 1'b0;
	time_value_t next_value;

	time_value_decimal_formatter #(
		.SECONDS_BITS(SEC_BITS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.seconds     (seconds),
		.microseconds(microseconds),
		.strobe      (strobe),
		.character   (character),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Formats one time value and appends its characters to expected_text.
	function automatic void format_time(input logic [SEC_BITS-1:0] sec_in,
			input logic [19:0] usec_in, input logic [2:0] dw_in, input logic [2:0] md_in);
		longint unsigned s, u, ures, wid, n, rem;
		int              w, m, nd, cnt;
		logic [7:0]      digs [20];
		logic [7:0]      txt [24];
		logic [7:0]      d;
		s = 64'(sec_in);
		u = 64'(usec_in);
		w = int'(dw_in);
		m = int'(md_in);
		// out-of-range registers and microseconds are pulled into range
		if (w < 1) w = 1;
		if (w > 6) w = 6;
		if (m > 6) m = 6;
		if (u > tvdf_pkg::US_MAX) u = 64'(tvdf_pkg::US_MAX);

		ures = ONE_MILLION / POW10[m];
		wid = POW10[w];
		// resolution follows the significant digits unless no decimals are allowed
		if (ures < ONE_MILLION) begin
			if (s > 0) begin
				n = 1;
				while (s >= n && n <= wid / 10)
					n = n * 10;
				ures = (ONE_MILLION / wid) * n;
			end else begin
				while (u >= wid * ures)
					ures = ures * 10;
			end
		end

		// round by half a step; may carry into the seconds, even past the field's top
		if (ures > 1) begin
			u = u + ures / 2;
			if (u >= ONE_MILLION) begin
				s = s + 1;
				u = u - ONE_MILLION;
			end
		end

		nd = 0;
		do begin
			d = 8'(s % 10);
			digs[nd] = tvdf_pkg::CHAR_ZERO + d;
			s = s / 10;
			nd++;
		end while (s > 0 && nd < 20);
		cnt = 0;
		for (int k = nd - 1; k >= 0; k--) begin
			txt[cnt] = digs[k];
			cnt++;
		end

		// fraction down to the resolution, trailing zeros dropped
		if (u >= ures) begin
			txt[cnt] = tvdf_pkg::CHAR_POINT;
			cnt++;
			rem = u;
			n = ONE_MILLION / 10;
			while (rem >= ures && n > 0) begin
				d = 8'((rem / n) % 10);
				txt[cnt] = tvdf_pkg::CHAR_ZERO + d;
				cnt++;
				rem = rem % n;
				n = n / 10;
			end
		end

		for (int k = 0; k < cnt; k++)
			expected_text.push_back('{character: txt[k], last: (k == cnt - 1)});
	endfunction

	// Driver: bursts of values with random gaps; now and then holds off until the
	// block has drained completely.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			burst_left = 0;
			gap_left = 0;
			draining = 1'b0;
		end else begin
			// transfer at this edge: predict with the registers now in effect
			if (start && !busy)
				format_time(seconds, microseconds, digit_width_cfg, max_decimals_cfg);

			if (start && busy) begin
				// not taken yet: keep holding the value
			end else if (draining) begin
				if (expected_text.size() == 0 && !busy)
					draining = 1'b0;
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_values.size() > 0) begin
				next_value = pending_values.pop_front();
				seconds <= next_value.sec;
				microseconds <= next_value.usec;
				start <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					// half the bursts follow with no gap at all
					gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 80);
					draining = ($urandom_range(0, 24) == 0);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed transfer must match the oldest expected character.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_text.size() == 0) begin
				$error("unexpected character %h (last %b)", character, last);
				error_count++;
			end else begin
				if (character !== expected_text[0].character) begin
					$error("character: expected %h, actual %h",
						expected_text[0].character, character);
					error_count++;
				end
				if (last !== expected_text[0].last) begin
					$error("last: expected %b, actual %b", expected_text[0].last, last);
					error_count++;
				end
				void'(expected_text.pop_front());
			end
		end
	end

	// Register write; only called with the block idle.
	task automatic write_reg(input logic [0:0] idx, input logic [2:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tvdf_pkg::REG_DIGIT_WIDTH)
			digit_width_cfg = val;
		else
			max_decimals_cfg = val;
	endtask

	// Blocks until nothing is queued, in flight or expected, then a short margin.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (!(pending_values.size() == 0 && !start && !draining &&
			expected_text.size() == 0 && !busy));
		repeat (8) @(negedge clk);
	endtask

	task automatic queue_random(input int count);
		logic [SEC_BITS-1:0] s;
		logic [19:0]         u;
		int                  pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				s = '0;
			else if (pick < 45)
				s = SEC_BITS'($urandom_range(1, 999));
			else if (pick < 60)
				s = SEC_BITS'($urandom_range(1000, 9999999));
			else if (pick < 85)
				s = SEC_BITS'($urandom);
			else
				s = {SEC_BITS{1'b1}} - SEC_BITS'($urandom_range(0, 50));

			pick = $urandom_range(0, 99);
			if (pick < 10)
				u = '0;
			else if (pick < 30)
				u = 20'($urandom_range(1, 999));
			else if (pick < 45)
				u = 20'($urandom_range(999000, 999999));   // rounding carry region
			else if (pick < 85)
				u = 20'($urandom_range(0, 999999));
			else
				u = 20'($urandom_range(1000000, 1048575)); // above range, clamped
			pending_values.push_back('{sec: s, usec: u});
		end
	endtask

	// register settings per phase: extremes, out-of-range codes, then mixes
	logic [2:0] phase_dw [8] = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd6, 3'd1, 3'd2, 3'd5};
	logic [2:0] phase_md [8] = '{3'd7, 3'd0, 3'd6, 3'd0, 3'd6, 3'd1, 3'd4, 3'd2};

	initial begin
		logic [2:0] dw, md;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed values under the reset settings
		pending_values.push_back('{sec: 0, usec: 0});
		pending_values.push_back('{sec: 0, usec: 1});
		pending_values.push_back('{sec: 0, usec: 999});
		pending_values.push_back('{sec: 0, usec: 1000});
		pending_values.push_back('{sec: 0, usec: 999499});
		pending_values.push_back('{sec: 0, usec: 999500});
		pending_values.push_back('{sec: 0, usec: 999999});
		pending_values.push_back('{sec: 0, usec: 20'hFFFFF});
		pending_values.push_back('{sec: 1, usec: 0});
		pending_values.push_back('{sec: 1, usec: 500000});
		pending_values.push_back('{sec: 9, usec: 999999});
		pending_values.push_back('{sec: 999, usec: 999500});
		pending_values.push_back('{sec: 1000, usec: 0});
		pending_values.push_back('{sec: 123456, usec: 789012});
		pending_values.push_back('{sec: {SEC_BITS{1'b1}}, usec: 0});
		// carry past the seconds field's largest value
		pending_values.push_back('{sec: {SEC_BITS{1'b1}}, usec: 999999});
		pending_values.push_back('{sec: {SEC_BITS{1'b1}}, usec: 20'hFFFFF});
		pending_values.push_back('{sec: 31'h40000000, usec: 500});
		pending_values.push_back('{sec: 31'h55555555, usec: 20'hAAAAA});
		pending_values.push_back('{sec: 31'h2AAAAAAA, usec: 20'h55555});
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 8) begin
				dw = phase_dw[ph];
				md = phase_md[ph];
			end else begin
				dw = 3'($urandom_range(0, 7));
				md = 3'($urandom_range(0, 7));
			end
			write_reg(tvdf_pkg::REG_DIGIT_WIDTH, dw);
			write_reg(tvdf_pkg::REG_MAX_DECIMALS, md);
			queue_random(RANDOM_PER_PHASE);
			wait_idle();
		end

		repeat (60) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS time_value_decimal_formatter");
		end else begin
			$display("FAIL time_value_decimal_formatter");
		end
		$finish;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL time_value_decimal_formatter");
		$finish;
	end

endmodule
